>>> src/vrt_pkg.sv
// ----------------------------------------------------------------------------
// vrt_pkg: shared types and constants of the virtual region table
// Address width, page mask, reset values, request codes, the slot and result
// structs, and the structs between the sequencer and the shared arithmetic unit.
// ----------------------------------------------------------------------------
package vrt_pkg;

    localparam int ADDR_W    = 48;
    localparam int SLOTS_DEF = 16;
    localparam int PROT_W    = 3;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [ADDR_W-1:0] PAGE_OFS   = ADDR_W'(12'hFFF);
    localparam logic [ADDR_W-1:0] BASE_RST   = ADDR_W'(64'h0000_0001_0000_0000);
    localparam logic [ADDR_W-1:0] LIMIT_RST  = ADDR_W'(64'h0000_7000_0000_0000);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 1'b1;

    // request codes carried in the input tuser
    typedef enum logic [MODE_W-1:0] {
        MODE_FIND  = 2'd0,
        MODE_MAP   = 2'd1,
        MODE_UNMAP = 2'd2
    } mode_t;

    // one stored region
    typedef struct packed {
        logic [PROT_W-1:0] prot;
        logic [ADDR_W-1:0] end_addr;
        logic [ADDR_W-1:0] start_addr;
    } slot_t;

    // operands for the shared unit: one adder, two magnitude compares
    typedef struct packed {
        logic [ADDR_W-1:0] add_a;
        logic [ADDR_W-1:0] add_b;
        logic [ADDR_W-1:0] cmp0_a;
        logic [ADDR_W-1:0] cmp0_b;
        logic [ADDR_W-1:0] cmp1_a;
        logic [ADDR_W-1:0] cmp1_b;
    } alu_req_t;

    typedef struct packed {
        logic [ADDR_W:0] sum;   // carry in the top bit
        logic            lt0;   // cmp0_a < cmp0_b
        logic            lt1;   // cmp1_a < cmp1_b
    } alu_rsp_t;

    // one result word
    typedef struct packed {
        logic              failed;
        logic [ADDR_W-1:0] map_base;
        logic              found;
        logic [ADDR_W-1:0] region_start;
        logic [ADDR_W-1:0] region_end;
        logic [PROT_W-1:0] region_prot;
    } result_t;

endpackage

>>> src/vrt_ram.sv
// ----------------------------------------------------------------------------
// vrt_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module vrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/vrt_alu.sv
// ----------------------------------------------------------------------------
// vrt_alu: shared arithmetic unit of the region table
// One address-wide adder with carry out and two magnitude compares, reused
// by every step of the sequencer.
// ----------------------------------------------------------------------------
module vrt_alu (
    input  vrt_pkg::alu_req_t req,
    output vrt_pkg::alu_rsp_t rsp
);
    import vrt_pkg::*;

    always_comb
    begin
        rsp.sum = {1'b0, req.add_a} + {1'b0, req.add_b};
        rsp.lt0 = req.cmp0_a < req.cmp0_b;
        rsp.lt1 = req.cmp1_a < req.cmp1_b;
    end

endmodule

>>> src/vrt_ctrl.sv
// ----------------------------------------------------------------------------
// vrt_ctrl: request sequencer of the region table
// Walks the slots one per cycle for find, map and unmap, drives the shared
// unit, owns the slot valid bits and the bump pointer.
// ----------------------------------------------------------------------------
module vrt_ctrl #(
    parameter int SLOTS = vrt_pkg::SLOTS_DEF,
    parameter int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [vrt_pkg::MODE_W-1:0]   in_mode,
    input  logic [vrt_pkg::ADDR_W-1:0]   in_addr,
    input  logic [vrt_pkg::ADDR_W-1:0]   in_len,
    input  logic [vrt_pkg::PROT_W-1:0]   in_prot,
    input  logic [vrt_pkg::ADDR_W-1:0]   region_base,
    input  logic [vrt_pkg::ADDR_W-1:0]   region_limit,
    input  logic                         res_ready,
    output logic                         idle,
    output logic                         done,
    output vrt_pkg::result_t             res,
    output logic                         ram_we,
    output logic [IDX_W-1:0]             ram_waddr,
    output vrt_pkg::slot_t               ram_wdata,
    output logic [IDX_W-1:0]             ram_raddr,
    input  vrt_pkg::slot_t               ram_rdata,
    output vrt_pkg::alu_req_t            alu_req,
    input  vrt_pkg::alu_rsp_t            alu_rsp
);
    import vrt_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PREP  = 6'b000010,
        S_SCAN  = 6'b000100,
        S_ADD   = 6'b001000,
        S_LIMIT = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [ADDR_W-1:0]   len_reg, len_next;
    logic [PROT_W-1:0]   prot_reg, prot_next;
    logic [ADDR_W-1:0]   lr_reg, lr_next;
    logic                ovf_reg, ovf_next;
    logic                to_top_reg, to_top_next;
    logic [ADDR_W-1:0]   hi_reg, hi_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [IDX_W-1:0]    slot_reg, slot_next;
    logic [ADDR_W-1:0]   next_free_reg, next_free_next;
    logic [SLOTS-1:0]    valid_reg, valid_next;
    result_t             res_reg, res_next;

    logic [ADDR_W-1:0]   lo;
    logic [IDX_W-1:0]    idx_inc;
    logic                last;
    logic                cur_valid;

    assign lo        = addr_reg & ~PAGE_OFS;
    assign idx_inc   = idx_reg + IDX_W'(1);
    assign last      = (idx_reg == IDX_W'(SLOTS - 1));
    assign cur_valid = valid_reg[idx_reg];

    assign idle      = (state_reg == S_IDLE);
    assign done      = (state_reg == S_DONE);
    assign res       = res_reg;
    assign ram_raddr = (state_reg == S_SCAN) ? idx_inc : '0;

    // operand selection for the shared unit
    always_comb
    begin
        alu_req = '0;
        case (state_reg)
            S_PREP:
            begin
                alu_req.add_a  = len_reg;
                alu_req.add_b  = PAGE_OFS;
                alu_req.cmp0_a = next_free_reg;
                alu_req.cmp0_b = region_base;
            end
            S_ADD:
            begin
                alu_req.add_a = (mode_reg == MODE_MAP) ? next_free_reg : lo;
                alu_req.add_b = lr_reg;
            end
            S_LIMIT:
            begin
                alu_req.cmp0_a = region_limit;
                alu_req.cmp0_b = hi_reg;
            end
            S_SCAN:
            begin
                if (mode_reg == MODE_FIND)
                begin
                    alu_req.cmp0_a = addr_reg;
                    alu_req.cmp0_b = ram_rdata.start_addr;
                    alu_req.cmp1_a = addr_reg;
                    alu_req.cmp1_b = ram_rdata.end_addr;
                end
                else
                begin
                    alu_req.cmp0_a = ram_rdata.start_addr;
                    alu_req.cmp0_b = lo;
                    alu_req.cmp1_a = hi_reg;
                    alu_req.cmp1_b = ram_rdata.end_addr;
                end
            end
            default:
            begin
                alu_req = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        addr_next      = addr_reg;
        len_next       = len_reg;
        prot_next      = prot_reg;
        lr_next        = lr_reg;
        ovf_next       = ovf_reg;
        to_top_next    = to_top_reg;
        hi_next        = hi_reg;
        idx_next       = idx_reg;
        slot_next      = slot_reg;
        next_free_next = next_free_reg;
        valid_next     = valid_reg;
        res_next       = res_reg;
        ram_we         = 1'b0;
        ram_waddr      = slot_reg;
        ram_wdata      = '{prot: prot_reg, end_addr: hi_reg, start_addr: next_free_reg};

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    mode_next  = in_mode;
                    addr_next  = in_addr;
                    len_next   = in_len;
                    prot_next  = in_prot;
                    res_next   = '0;
                    idx_next   = '0;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                // round length up to pages; carry means it does not fit
                lr_next  = alu_rsp.sum[ADDR_W-1:0] & ~PAGE_OFS;
                ovf_next = alu_rsp.sum[ADDR_W];
                case (mode_reg)
                    MODE_FIND:
                    begin
                        state_next = S_SCAN;
                    end
                    MODE_MAP:
                    begin
                        if (len_reg == '0)
                        begin
                            res_next.failed = 1'b1;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            if (alu_rsp.lt0)
                            begin
                                next_free_next = region_base;
                            end
                            state_next = S_SCAN;
                        end
                    end
                    MODE_UNMAP:
                    begin
                        if (len_reg == '0)
                        begin
                            res_next.failed = 1'b1;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            state_next = S_ADD;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SCAN:
            begin
                idx_next = idx_inc;
                case (mode_reg)
                    MODE_FIND:
                    begin
                        if (cur_valid && !alu_rsp.lt0 && alu_rsp.lt1)
                        begin
                            res_next.found        = 1'b1;
                            res_next.region_start = ram_rdata.start_addr;
                            res_next.region_end   = ram_rdata.end_addr;
                            res_next.region_prot  = ram_rdata.prot;
                            state_next            = S_DONE;
                        end
                        else if (last)
                        begin
                            state_next = S_DONE;
                        end
                    end
                    MODE_MAP:
                    begin
                        if (!cur_valid)
                        begin
                            slot_next  = idx_reg;
                            state_next = S_ADD;
                        end
                        else if (last)
                        begin
                            res_next.failed = 1'b1;
                            state_next      = S_DONE;
                        end
                    end
                    MODE_UNMAP:
                    begin
                        if (cur_valid && !alu_rsp.lt0 && (to_top_reg || !alu_rsp.lt1))
                        begin
                            valid_next[idx_reg] = 1'b0;
                        end
                        if (last)
                        begin
                            state_next = S_DONE;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_ADD:
            begin
                hi_next = alu_rsp.sum[ADDR_W-1:0];
                if (mode_reg == MODE_MAP)
                begin
                    if (ovf_reg || alu_rsp.sum[ADDR_W])
                    begin
                        res_next.failed = 1'b1;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_LIMIT;
                    end
                end
                else
                begin
                    // range past the top of the address space reaches the top
                    to_top_next = ovf_reg || alu_rsp.sum[ADDR_W];
                    idx_next    = '0;
                    state_next  = S_SCAN;
                end
            end
            S_LIMIT:
            begin
                if (alu_rsp.lt0)
                begin
                    res_next.failed = 1'b1;
                end
                else
                begin
                    ram_we               = 1'b1;
                    valid_next[slot_reg] = 1'b1;
                    next_free_next       = hi_reg;
                    res_next.map_base    = next_free_reg;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            next_free_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            next_free_reg <= next_free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        addr_reg   <= addr_next;
        len_reg    <= len_next;
        prot_reg   <= prot_next;
        lr_reg     <= lr_next;
        ovf_reg    <= ovf_next;
        to_top_reg <= to_top_next;
        hi_reg     <= hi_next;
        idx_reg    <= idx_next;
        slot_reg   <= slot_next;
        res_reg    <= res_next;
    end

    // a committed map leaves its slot valid
    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LIMIT && !alu_rsp.lt0) |=> valid_reg[$past(slot_reg)])
        else $error("mapped slot not marked valid");

    // the bump pointer only moves upward
    a_ptr_mono: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |=> next_free_reg >= $past(next_free_reg))
        else $error("bump pointer moved down");

    // a found region is never empty
    a_found_order: assert property (@(posedge clk) disable iff (!rst_n)
        (done && res_reg.found) |-> res_reg.region_start < res_reg.region_end)
        else $error("found region has start not below end");

    // one answer kind per request
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(res_reg.found && res_reg.failed))
        else $error("result both found and failed");

endmodule

>>> src/virtual_region_table.sv
// ----------------------------------------------------------------------------
// virtual_region_table: region table and bump allocator of one process
// Find, map and unmap requests over a small table of virtual regions.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel, one word each: tuser selects find,
//   map or unmap, tdata carries address, length and protection. Every request
//   gives exactly one result word on the m_axis channel (flags in tuser,
//   addresses and protection in tdata).
//   The sequencer handles one request at a time and deasserts s_axis_tready
//   from acceptance until the result is handed to the output register. After
//   a preparation step that rounds the length, each request goes on as follows:
//     find    : walks the slots up to the first hit or the last slot
//     map     : walks to the lowest free slot, adds the length, checks the limit
//     unmap   : adds the length to the page of the address, then walks every slot
//   The slot walk goes one slot per cycle through the shared add/compare unit
//   and the single read port of the slot RAM.
//   The result sits in an output register; while the receiver stalls, the
//   next request is still accepted and processed up to its answer, which then
//   waits until the register frees.
//   Reset clears all slot valid bits, the bump pointer and both channels at
//   once; no clearing pass is needed. cfg_we writes region_base (index 0) or
//   region_limit (index 1); write them only while the block is idle.
// ----------------------------------------------------------------------------
module virtual_region_table #(
    parameter int SLOTS = vrt_pkg::SLOTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // config port
    input  logic                          cfg_we,
    input  logic [vrt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [vrt_pkg::ADDR_W-1:0]    cfg_data,
    // request channel
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [103:0]                  s_axis_tdata,  // addr, length, prot, zero pad
    input  logic [1:0]                    s_axis_tuser,  // mode
    // result channel
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [151:0]                  m_axis_tdata,  // map_base, region_start,
                                                         // region_end, region_prot, pad
    output logic [1:0]                    m_axis_tuser   // failed, found
);
    import vrt_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [ADDR_W-1:0] base_reg, base_next;
    logic [ADDR_W-1:0] limit_reg, limit_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg, out_next;

    logic              idle;
    logic              done;
    logic              start;
    logic              res_ready;
    result_t           res;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [IDX_W-1:0]  ram_raddr;
    slot_t             ram_wdata;
    slot_t             ram_rdata;
    alu_req_t          alu_req;
    alu_rsp_t          alu_rsp;

    // take a request only while the sequencer waits for one
    assign s_axis_tready = idle;
    assign start         = s_axis_tvalid && idle;

    // the output register is free when empty or being drained
    assign res_ready = !out_valid_reg || m_axis_tready;

    vrt_ctrl #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .in_mode      (s_axis_tuser),
        .in_addr      (s_axis_tdata[47:0]),
        .in_len       (s_axis_tdata[95:48]),
        .in_prot      (s_axis_tdata[98:96]),
        .region_base  (base_reg),
        .region_limit (limit_reg),
        .res_ready    (res_ready),
        .idle         (idle),
        .done         (done),
        .res          (res),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .alu_req      (alu_req),
        .alu_rsp      (alu_rsp)
    );

    vrt_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // slot payload store: start, end and protection of each region
    vrt_ram #(
        .WIDTH ($bits(slot_t)),
        .DEPTH (SLOTS),
        .AW    (IDX_W)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // configuration registers
    always_comb
    begin
        base_next  = base_reg;
        limit_next = limit_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_BASE:  base_next  = cfg_data;
                CFG_LIMIT: limit_next = cfg_data;
                default:   base_next  = base_reg;
            endcase
        end
    end

    // output register: load the finished result, drop it once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (done && res_ready)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= BASE_RST;
            limit_reg     <= LIMIT_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            base_reg      <= base_next;
            limit_reg     <= limit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = {out_reg.found, out_reg.failed};
    assign m_axis_tdata  = {5'b0, out_reg.region_prot, out_reg.region_end,
                            out_reg.region_start, out_reg.map_base};

endmodule

>>> test/virtual_region_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// virtual_region_table_tb: self-checking bench for the virtual region table
// Sends find, map and unmap words through the request channel. A scoreboard
// keeps its own copy of the region table and bump pointer, predicts each
// answer on acceptance, and checks every result word in order. Random idle
// and stall bursts on both channels, plus one long result hold-off.
// ----------------------------------------------------------------------------
module virtual_region_table_tb;
    import vrt_pkg::*;

    localparam int                SLOTS        = SLOTS_DEF;
    localparam logic [ADDR_W-1:0] ADDR_MAX     = '1;
    localparam int                SETTLE_TICKS = 40;      // beyond the longest walk
    localparam int                CYCLE_LIMIT  = 400000;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow region table, bump pointer and the queue of answers
    // still owed by the block.
    // ------------------------------------------------------------------------
    class region_board;
        logic [ADDR_W-1:0] base_reg;
        logic [ADDR_W-1:0] limit_reg;
        logic [ADDR_W-1:0] bump;
        bit                live      [SLOTS];
        logic [ADDR_W-1:0] lo_addr   [SLOTS];
        logic [ADDR_W-1:0] hi_addr   [SLOTS];
        logic [PROT_W-1:0] prot_bits [SLOTS];
        result_t           pending_answers [$];
        int                errors;

        function new();
            base_reg  = BASE_RST;
            limit_reg = LIMIT_RST;
            bump      = '0;
            errors    = 0;
            for (int i = 0; i < SLOTS; i++) live[i] = 1'b0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] value);
            if (idx == CFG_BASE)
                base_reg = value;
            else if (idx == CFG_LIMIT)
                limit_reg = value;
        endfunction

        // round up to whole pages; refuse anything that would pass the top
        function bit round_pages(input logic [ADDR_W-1:0] len,
                                 output logic [ADDR_W-1:0] rounded);
            if (len > ADDR_MAX - PAGE_OFS)
                return 1'b0;
            rounded = (len + PAGE_OFS) & ~PAGE_OFS;
            return 1'b1;
        endfunction

        // predict the answer to one accepted request and advance the shadow
        function void note_request(mode_t mode, logic [ADDR_W-1:0] addr,
                                   logic [ADDR_W-1:0] len, logic [PROT_W-1:0] prot);
            result_t           ans;
            logic [ADDR_W-1:0] rounded;
            logic [ADDR_W-1:0] lo;
            logic [ADDR_W-1:0] hi;
            int                slot;
            bit                to_top;
            ans = '0;
            case (mode)
                MODE_FIND:
                    for (int i = 0; i < SLOTS; i++)
                        if (!ans.found && live[i] && addr >= lo_addr[i] && addr < hi_addr[i])
                        begin
                            ans.found        = 1'b1;
                            ans.region_start = lo_addr[i];
                            ans.region_end   = hi_addr[i];
                            ans.region_prot  = prot_bits[i];
                        end
                MODE_MAP:
                begin
                    ans.failed = 1'b1;
                    if (len != 0)
                    begin
                        // the pointer is raised even if the map fails later on
                        if (bump < base_reg)
                            bump = base_reg;
                        slot = -1;
                        for (int i = 0; i < SLOTS; i++)
                            if (slot < 0 && !live[i])
                                slot = i;
                        if (slot >= 0 && round_pages(len, rounded) && rounded <= ADDR_MAX - bump
                            && bump + rounded <= limit_reg)
                        begin
                            ans.failed      = 1'b0;
                            ans.map_base    = bump;
                            lo_addr[slot]   = bump;
                            hi_addr[slot]   = bump + rounded;
                            prot_bits[slot] = prot;
                            live[slot]      = 1'b1;
                            bump            = bump + rounded;
                        end
                    end
                end
                MODE_UNMAP:
                begin
                    if (len == 0)
                        ans.failed = 1'b1;
                    else
                    begin
                        lo     = addr & ~PAGE_OFS;
                        to_top = !round_pages(len, rounded) || rounded > ADDR_MAX - lo;
                        hi     = to_top ? ADDR_MAX : lo + rounded;
                        for (int i = 0; i < SLOTS; i++)
                            if (live[i] && lo_addr[i] >= lo && (to_top || hi_addr[i] <= hi))
                                live[i] = 1'b0;
                    end
                end
                default: ;
            endcase
            pending_answers.push_back(ans);
        endfunction

        function void check_answer(result_t got);
            result_t want;
            if (pending_answers.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result word: %p", got);
                return;
            end
            want = pending_answers.pop_front();
            if (got.failed !== want.failed || got.map_base !== want.map_base
                || got.found !== want.found || got.region_start !== want.region_start
                || got.region_end !== want.region_end || got.region_prot !== want.region_prot)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("mismatch  expected failed=%0b base=%h found=%0b start=%h end=%h prot=%0d",
                             want.failed, want.map_base, want.found, want.region_start,
                             want.region_end, want.region_prot);
                    $display("          actual   failed=%0b base=%h found=%0b start=%h end=%h prot=%0d",
                             got.failed, got.map_base, got.found, got.region_start,
                             got.region_end, got.region_prot);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block and its ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [ADDR_W-1:0]    cfg_data      = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [103:0]         s_axis_tdata  = '0;   // addr, length, prot, zero pad
    logic [1:0]           s_axis_tuser  = '0;   // mode
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b1;
    logic [151:0]         m_axis_tdata;         // map_base, region_start, region_end,
                                                // region_prot, pad
    logic [1:0]           m_axis_tuser;         // failed, found

    region_board board;
    bit          idle_on      = 1'b1;   // random gaps and stalls allowed
    bit          hold_off_req = 1'b0;   // ask the result side for one long stall

    virtual_region_table dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------------
    // Result side: check every accepted word, stall in random bursts, and
    // hold off for a long stretch once so the block backs up into its input.
    // ------------------------------------------------------------------------
    initial
    begin : result_side
        int      hold;
        result_t got;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.failed       = m_axis_tuser[0];
                got.found        = m_axis_tuser[1];
                got.map_base     = m_axis_tdata[47:0];
                got.region_start = m_axis_tdata[95:48];
                got.region_end   = m_axis_tdata[143:96];
                got.region_prot  = m_axis_tdata[146:144];
                board.check_answer(got);
            end
            if (hold > 0)
            begin
                hold--;
                if (hold == 0)
                    m_axis_tready <= 1'b1;
            end
            else if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold = 500;
                m_axis_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 11) == 0)
            begin
                hold = $urandom_range(1, 14);
                m_axis_tready <= 1'b0;
            end
        end
    end

    // timeout: count cycles and give up well past the slowest correct run
    initial
    begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    function automatic logic [ADDR_W-1:0] rand_addr();
        return ADDR_W'({$urandom(), $urandom()});
    endfunction

    // random live slot of the shadow table, -1 when the table is empty
    function automatic int pick_live();
        int n;
        int k;
        n = 0;
        for (int i = 0; i < SLOTS; i++)
            if (board.live[i])
                n++;
        if (n == 0)
            return -1;
        k = $urandom_range(0, n - 1);
        for (int i = 0; i < SLOTS; i++)
            if (board.live[i])
            begin
                if (k == 0)
                    return i;
                k--;
            end
        return -1;
    endfunction

    // offer one word, optionally after an idle burst; note it on acceptance
    task automatic issue(mode_t mode, logic [ADDR_W-1:0] addr, logic [ADDR_W-1:0] len,
                         logic [PROT_W-1:0] prot);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 14);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {5'b0, prot, len, addr};
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.note_request(mode, addr, len, prot);
    endtask

    // drop valid, wait until every answer is in, then let the block go quiet
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (board.pending_answers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    // one write strobe, then cfg_we low again before the next write may start
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.set_reg(idx, value);
        @(posedge clk);
    endtask

    // mostly well-formed traffic aimed at live regions, with some noise
    task automatic random_request(output mode_t mode, output logic [ADDR_W-1:0] addr,
                                 output logic [ADDR_W-1:0] len,
                                 output logic [PROT_W-1:0] prot);
        int                r;
        int                k;
        logic [ADDR_W-1:0] span;
        r    = $urandom_range(0, 99);
        addr = rand_addr();
        len  = rand_addr();
        prot = PROT_W'($urandom_range(0, 7));
        k    = pick_live();
        if (r < 40)
        begin
            mode = MODE_FIND;
            if (k >= 0 && $urandom_range(0, 4) != 0)
            begin
                span = board.hi_addr[k] - board.lo_addr[k];
                case ($urandom_range(0, 3))
                    0:       addr = board.lo_addr[k];
                    1:       addr = board.hi_addr[k] - 1;
                    2:       addr = board.hi_addr[k];          // exclusive end
                    default: addr = board.lo_addr[k] + rand_addr() % span;
                endcase
            end
        end
        else if (r < 75)
        begin
            mode = MODE_MAP;
            case ($urandom_range(0, 19))
                0:       len = '0;
                1:       ;                                     // huge, random
                2:       len = ADDR_MAX - ADDR_W'($urandom_range(0, 'h2000));
                default: len = ADDR_W'($urandom_range(1, 'h9000));
            endcase
        end
        else
        begin
            mode = MODE_UNMAP;
            case ($urandom_range(0, 9))
                0:       len = '0;
                1:       addr = ADDR_W'($urandom_range(0, 'hFFFF));  // low address, random length
                2, 3:    ;                                          // random range
                default:
                    if (k >= 0)
                    begin
                        // cover the region, sometimes a page short of it
                        addr = board.lo_addr[k];
                        if ($urandom_range(0, 1) == 1)
                            addr = addr + ADDR_W'($urandom_range(0, 'hFFF));
                        len = board.hi_addr[k] - (addr & ~PAGE_OFS)
                              + ADDR_W'($urandom_range(0, 'h1800));
                        if ($urandom_range(0, 4) == 0)
                            len = len - 'h1000;
                    end
            endcase
        end
    endtask

    task automatic run_phase(int count, int hold_at);
        mode_t             mode;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] len;
        logic [PROT_W-1:0] prot;
        for (int n = 0; n < count; n++)
        begin
            if (n == hold_at)
                hold_off_req = 1'b1;
            random_request(mode, addr, len, prot);
            issue(mode, addr, len, prot);
        end
        settle();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_flow
        board = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, reset register values
        issue(MODE_FIND,  '0, '0, '0);                          // empty table
        issue(MODE_MAP,   '0, '0, 3'd7);                        // zero length
        issue(MODE_MAP,   '0, 48'd1, 3'd7);                     // one byte, one page
        issue(MODE_MAP,   '0, ADDR_MAX, 3'd1);                  // rounding overflows
        issue(MODE_MAP,   '0, ADDR_MAX - PAGE_OFS, 3'd2);       // passes the top
        issue(MODE_MAP,   '0, 48'h7000_0000_0000, 3'd3);        // over the limit
        for (int i = 1; i < SLOTS; i++)
            issue(MODE_MAP, ADDR_MAX, ADDR_W'(i * 'h1100), PROT_W'(i));
        issue(MODE_MAP,   '0, 48'h1000, 3'd4);                  // table full
        issue(MODE_FIND,  48'h1_0000_0800, '0, '0);             // inside the first region
        issue(MODE_FIND,  48'h1_0000_1000, '0, '0);             // end belongs to the next
        issue(MODE_UNMAP, 48'h1_0000_0000, '0, '0);             // zero length
        issue(MODE_UNMAP, 48'h1_0000_0123, 48'hFFF, '0);        // exactly the first region
        issue(MODE_UNMAP, ADDR_MAX, 48'd1, '0);                 // past the top, covers nothing
        issue(MODE_UNMAP, '0, ADDR_MAX, '0);                    // wipe everything
        settle();

        // default registers, with one long stall on the result side
        run_phase(550, 120);

        // lowest base, widest limit
        write_reg(CFG_BASE, '0);
        write_reg(CFG_LIMIT, ADDR_MAX);
        run_phase(200, -1);

        // tight limit just above the pointer: room for 48 pages only
        write_reg(CFG_LIMIT, board.bump + 48'h3_0000);
        run_phase(200, -1);

        // page-aligned base close to the top of the address space
        write_reg(CFG_BASE, ADDR_MAX - 48'h1_0FFF);
        write_reg(CFG_LIMIT, ADDR_MAX);
        run_phase(200, -1);

        // highest base, zero limit; no gaps or stalls from here on
        idle_on = 1'b0;
        write_reg(CFG_BASE, ADDR_MAX);
        write_reg(CFG_LIMIT, '0);
        run_phase(150, -1);

        if (board.errors == 0 && board.pending_answers.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> files.f
src/vrt_pkg.sv
src/vrt_ram.sv
src/vrt_alu.sv
src/vrt_ctrl.sv
src/virtual_region_table.sv
test/virtual_region_table_tb.sv
